FILE: rtl/ppgi_pkg.sv
// Shared types, codes and constants of the periodic polar grid interpolator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ppgi_pkg;

  localparam int DEF_NUM_MODES  = 4;
  localparam int DEF_NUM_RADII  = 64;
  localparam int DEF_NUM_ANGLES = 64;

  localparam int OP_W       = 2;
  localparam int MODE_W     = 3;
  localparam int RIDX_W     = 6;
  localparam int AIDX_W     = 7;
  localparam int VAL_W      = 32;
  localparam int SPACING_W  = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Multiplier operand width, product width, offset width and accumulator width.
  localparam int MW = 34;
  localparam int PW = 2 * MW;
  localparam int XW = 44;
  localparam int AW = 64;

  localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
  localparam logic [OP_W-1:0] OP_BILINEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_LINEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_ORIGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SPACING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_INVERSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_ORIGIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SPACING  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_INVERSE  = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [MODE_W-1:0]        mode_index;
    logic [RIDX_W-1:0]        radius_index;
    logic [AIDX_W-1:0]        angle_index;
    logic signed [VAL_W-1:0]  radius_location;
    logic signed [VAL_W-1:0]  angle_location;
    logic signed [VAL_W-1:0]  write_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] interpolated_value;
    logic                    status;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_WRITE,
    S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_Q6, S_Q7, S_Q8, S_Q9, S_Q10,
    S_Q11, S_Q12, S_Q13, S_Q14, S_Q15, S_Q16, S_Q17, S_Q18, S_Q19, S_Q20,
    S_L6, S_L7, S_L8, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    MUL_IA_DT, MUL_IR_DR,
    MUL_XA_LO, MUL_XA_HI, MUL_YA_LO, MUL_YA_HI,
    MUL_XR_LO, MUL_XR_HI, MUL_YR_LO, MUL_YR_HI,
    MUL_TR, MUL_TL, MUL_BR, MUL_BL, MUL_TOP, MUL_BOT, MUL_DIFF
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_SET_LO, ACC_ADD_LO, ACC_ADD_HI, ACC_SET_BASE, ACC_LD_ANG, ACC_LD_RAD
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_NONE, ST_WTR, ST_WTL, ST_WRU, ST_WRL, ST_TOP, ST_BOT, ST_RES, ST_ZERO
  } store_sel_t;

  typedef enum logic [2:0] {
    CORNER_TR, CORNER_TL, CORNER_BR, CORNER_BL, CORNER_WR
  } corner_t;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_TR, CAP_TL, CAP_BR, CAP_BL
  } cap_sel_t;

  typedef struct packed {
    mul_sel_t   mul;
    acc_op_t    acc;
    store_sel_t st;
    corner_t    corner;
    cap_sel_t   cap;
    logic       capture;
    logic       ram_we;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok;
  } dp_status_t;

endpackage

FILE: rtl/ppgi_ram.sv
// Generic single-port RAM with one write or read address per cycle and registered read data.
// Stands alone; holds the value table of the interpolator.
module ppgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/ppgi_ctrl.sv
// Sequencing state machine of the interpolator: handshakes and datapath commands.
// Depends on ppgi_pkg.
module ppgi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ppgi_pkg::dp_status_t status,
  output ppgi_pkg::dp_cmd_t    cmd
);
  import ppgi_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd.mul        = MUL_IA_DT;
    cmd.acc        = ACC_HOLD;
    cmd.st         = ST_NONE;
    cmd.corner     = CORNER_TR;
    cmd.cap        = CAP_NONE;
    cmd.capture    = 1'b0;
    cmd.ram_we     = 1'b0;
    cmd.out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.st = ST_ZERO;
        if (!status.ok) begin
          state_next = S_OUT;
        end else if (status.op == OP_WRITE) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_Q0;
        end
      end
      S_WRITE: begin
        cmd.corner = CORNER_WR;
        cmd.ram_we = 1'b1;
        state_next = S_OUT;
      end
      S_Q0: begin
        cmd.mul    = MUL_IA_DT;
        cmd.corner = CORNER_TR;
        state_next = S_Q1;
      end
      S_Q1: begin
        cmd.acc    = ACC_LD_ANG;
        cmd.corner = CORNER_TL;
        cmd.cap    = CAP_TR;
        state_next = S_Q2;
      end
      S_Q2: begin
        cmd.mul    = MUL_XA_LO;
        cmd.corner = CORNER_BR;
        cmd.cap    = CAP_TL;
        state_next = S_Q3;
      end
      S_Q3: begin
        cmd.mul    = MUL_XA_HI;
        cmd.acc    = ACC_SET_LO;
        cmd.corner = CORNER_BL;
        cmd.cap    = CAP_BR;
        state_next = S_Q4;
      end
      S_Q4: begin
        cmd.mul    = MUL_YA_LO;
        cmd.acc    = ACC_ADD_HI;
        cmd.cap    = CAP_BL;
        state_next = S_Q5;
      end
      S_Q5: begin
        cmd.mul    = MUL_YA_HI;
        cmd.acc    = ACC_SET_LO;
        cmd.st     = ST_WTR;
        state_next = (status.op == OP_LINEAR) ? S_L6 : S_Q6;
      end
      S_Q6: begin
        cmd.mul    = MUL_IR_DR;
        cmd.acc    = ACC_ADD_HI;
        state_next = S_Q7;
      end
      S_Q7: begin
        cmd.acc    = ACC_LD_RAD;
        cmd.st     = ST_WTL;
        state_next = S_Q8;
      end
      S_Q8: begin
        cmd.mul    = MUL_XR_LO;
        state_next = S_Q9;
      end
      S_Q9: begin
        cmd.mul    = MUL_XR_HI;
        cmd.acc    = ACC_SET_LO;
        state_next = S_Q10;
      end
      S_Q10: begin
        cmd.mul    = MUL_YR_LO;
        cmd.acc    = ACC_ADD_HI;
        state_next = S_Q11;
      end
      S_Q11: begin
        cmd.mul    = MUL_YR_HI;
        cmd.acc    = ACC_SET_LO;
        cmd.st     = ST_WRU;
        state_next = S_Q12;
      end
      S_Q12: begin
        cmd.mul    = MUL_TR;
        cmd.acc    = ACC_ADD_HI;
        state_next = S_Q13;
      end
      S_Q13: begin
        cmd.mul    = MUL_TL;
        cmd.acc    = ACC_SET_LO;
        cmd.st     = ST_WRL;
        state_next = S_Q14;
      end
      S_Q14: begin
        cmd.mul    = MUL_BR;
        cmd.acc    = ACC_ADD_LO;
        state_next = S_Q15;
      end
      S_Q15: begin
        cmd.mul    = MUL_BL;
        cmd.acc    = ACC_SET_LO;
        cmd.st     = ST_TOP;
        state_next = S_Q16;
      end
      S_Q16: begin
        cmd.mul    = MUL_TOP;
        cmd.acc    = ACC_ADD_LO;
        state_next = S_Q17;
      end
      S_Q17: begin
        cmd.acc    = ACC_SET_LO;
        cmd.st     = ST_BOT;
        state_next = S_Q18;
      end
      S_Q18: begin
        cmd.mul    = MUL_BOT;
        state_next = S_Q19;
      end
      S_Q19: begin
        cmd.acc    = ACC_ADD_LO;
        state_next = S_Q20;
      end
      S_Q20: begin
        cmd.st     = ST_RES;
        state_next = S_OUT;
      end
      S_L6: begin
        cmd.mul    = MUL_DIFF;
        state_next = S_L7;
      end
      S_L7: begin
        cmd.acc    = ACC_SET_BASE;
        state_next = S_L8;
      end
      S_L8: begin
        cmd.st     = ST_RES;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: rtl/ppgi_datapath.sv
// Datapath of the interpolator: settings registers, value table, shared multiplier,
// accumulator, weight and corner registers and the output register. Depends on ppgi_pkg
// and ppgi_ram.
module ppgi_datapath #(
  parameter int NUM_MODES  = ppgi_pkg::DEF_NUM_MODES,
  parameter int NUM_RADII  = ppgi_pkg::DEF_NUM_RADII,
  parameter int NUM_ANGLES = ppgi_pkg::DEF_NUM_ANGLES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ppgi_pkg::in_word_t                  in_data,
  output ppgi_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ppgi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppgi_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ppgi_pkg::dp_cmd_t                   cmd,
  output ppgi_pkg::dp_status_t                status
);
  import ppgi_pkg::*;

  localparam int DEPTH  = NUM_MODES * NUM_RADII * NUM_ANGLES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RW     = $clog2(NUM_RADII);
  localparam int CW     = $clog2(NUM_ANGLES);
  localparam logic [ADDR_W-1:0] NR_A = ADDR_W'(NUM_RADII);
  localparam logic [ADDR_W-1:0] NA_A = ADDR_W'(NUM_ANGLES);

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [AW-1:0] v);
    logic fits;
    fits = (&v[AW-1:VAL_W-1]) | ~(|v[AW-1:VAL_W-1]);
    if (fits) begin
      return v[VAL_W-1:0];
    end else if (v[AW-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

  logic signed [VAL_W-1:0]     radius_origin;
  logic [SPACING_W-1:0]        radius_spacing;
  logic [VAL_W-1:0]            radius_inverse;
  logic signed [VAL_W-1:0]     angle_origin;
  logic [SPACING_W-1:0]        angle_spacing;
  logic [VAL_W-1:0]            angle_inverse;

  in_word_t                    in_q;
  logic signed [XW-1:0]        xa, ya, xr, yr;
  logic signed [VAL_W-1:0]     v_tr, v_tl, v_br, v_bl;
  logic signed [VAL_W-1:0]     wtr, wtl, wru, wrl, top, bot, res_value;
  logic signed [PW-1:0]        prod_q;
  logic signed [AW-1:0]        acc;

  logic signed [MW-1:0]        opa, opb;
  logic signed [PW-1:0]        prod;
  logic signed [AW-1:0]        term_lo, term_hi;
  logic signed [VAL_W-1:0]     acc_sat;

  logic                        mode_ok, ir_ok, ia_lt, ia_le, ok;
  logic [MODE_W-1:0]           plane;
  logic [RW-1:0]               row_up, row_dn, row;
  logic [CW-1:0]               col_r, col_l, col;
  logic [ADDR_W-1:0]           ram_addr;
  logic [VAL_W-1:0]            ram_rdata;

  // Settings registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_origin  <= '0;
      radius_spacing <= SPACING_W'(65536);
      radius_inverse <= VAL_W'(65536);
      angle_origin   <= '0;
      angle_spacing  <= SPACING_W'(65536);
      angle_inverse  <= VAL_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS_ORIGIN:  radius_origin  <= cfg_data;
        REG_RADIUS_SPACING: radius_spacing <= cfg_data[SPACING_W-1:0];
        REG_RADIUS_INVERSE: radius_inverse <= cfg_data;
        REG_ANGLE_ORIGIN:   angle_origin   <= cfg_data;
        REG_ANGLE_SPACING:  angle_spacing  <= cfg_data[SPACING_W-1:0];
        REG_ANGLE_INVERSE:  angle_inverse  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Index checks on the captured word.
  always_comb begin
    mode_ok = (in_q.mode_index != '0) && (32'(in_q.mode_index) <= 32'(NUM_MODES));
    ir_ok   = 32'(in_q.radius_index) < 32'(NUM_RADII);
    ia_lt   = 32'(in_q.angle_index) < 32'(NUM_ANGLES);
    ia_le   = 32'(in_q.angle_index) <= 32'(NUM_ANGLES);
    ok      = mode_ok && ir_ok &&
              (((in_q.op == OP_WRITE) && ia_lt) ||
               ((in_q.op == OP_LINEAR) && ia_le) ||
               ((in_q.op == OP_BILINEAR) && ia_le && (in_q.radius_index != '0)));
  end

  assign status.op = in_q.op;
  assign status.ok = ok;

  // Table addressing; the angle axis wraps at both ends.
  always_comb begin
    plane  = in_q.mode_index - MODE_W'(1);
    row_up = RW'(in_q.radius_index);
    row_dn = RW'(in_q.radius_index - RIDX_W'(1));
    col_r  = (32'(in_q.angle_index) == 32'(NUM_ANGLES)) ? '0 : CW'(in_q.angle_index);
    col_l  = (in_q.angle_index == '0) ? CW'(NUM_ANGLES - 1)
                                      : CW'(in_q.angle_index - AIDX_W'(1));
    unique case (cmd.corner)
      CORNER_TR: begin
        row = row_up;
        col = col_r;
      end
      CORNER_TL: begin
        row = row_up;
        col = col_l;
      end
      CORNER_BR: begin
        row = row_dn;
        col = col_r;
      end
      CORNER_BL: begin
        row = row_dn;
        col = col_l;
      end
      CORNER_WR: begin
        row = row_up;
        col = CW'(in_q.angle_index);
      end
      default: begin
        row = row_up;
        col = col_r;
      end
    endcase
    ram_addr = (ADDR_W'(plane) * NR_A + ADDR_W'(row)) * NA_A + ADDR_W'(col);
  end

  ppgi_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (ram_addr),
    .wdata (in_q.write_value),
    .rdata (ram_rdata)
  );

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd.mul)
      MUL_IA_DT: begin
        opa = MW'(in_q.angle_index);
        opb = MW'(angle_spacing);
      end
      MUL_IR_DR: begin
        opa = MW'(in_q.radius_index);
        opb = MW'(radius_spacing);
      end
      MUL_XA_LO: begin
        opa = MW'(xa[VAL_W-1:0]);
        opb = MW'(angle_inverse);
      end
      MUL_XA_HI: begin
        opa = MW'($signed(xa[XW-1:VAL_W]));
        opb = MW'(angle_inverse);
      end
      MUL_YA_LO: begin
        opa = MW'(ya[VAL_W-1:0]);
        opb = MW'(angle_inverse);
      end
      MUL_YA_HI: begin
        opa = MW'($signed(ya[XW-1:VAL_W]));
        opb = MW'(angle_inverse);
      end
      MUL_XR_LO: begin
        opa = MW'(xr[VAL_W-1:0]);
        opb = MW'(radius_inverse);
      end
      MUL_XR_HI: begin
        opa = MW'($signed(xr[XW-1:VAL_W]));
        opb = MW'(radius_inverse);
      end
      MUL_YR_LO: begin
        opa = MW'(yr[VAL_W-1:0]);
        opb = MW'(radius_inverse);
      end
      MUL_YR_HI: begin
        opa = MW'($signed(yr[XW-1:VAL_W]));
        opb = MW'(radius_inverse);
      end
      MUL_TR: begin
        opa = MW'(v_tr);
        opb = MW'(wtr);
      end
      MUL_TL: begin
        opa = MW'(v_tl);
        opb = MW'(wtl);
      end
      MUL_BR: begin
        opa = MW'(v_br);
        opb = MW'(wtr);
      end
      MUL_BL: begin
        opa = MW'(v_bl);
        opb = MW'(wtl);
      end
      MUL_TOP: begin
        opa = MW'(top);
        opb = MW'(wru);
      end
      MUL_BOT: begin
        opa = MW'(bot);
        opb = MW'(wrl);
      end
      MUL_DIFF: begin
        opa = MW'(v_tr) - MW'(v_tl);
        opb = MW'(wtr);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    prod = opa * opb;
  end

  // Floored product, and the high partial product of a wide offset times a reciprocal.
  assign term_lo = {{(AW-PW+16){prod_q[PW-1]}}, prod_q[PW-1:16]};
  assign term_hi = {prod_q[AW-17:0], 16'b0};
  assign acc_sat = sat32(acc);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q <= in_data;
    end
    prod_q <= prod;

    unique case (cmd.acc)
      ACC_HOLD: begin
      end
      ACC_SET_LO:   acc <= term_lo;
      ACC_ADD_LO:   acc <= acc + term_lo;
      ACC_ADD_HI:   acc <= acc + term_hi;
      ACC_SET_BASE: acc <= AW'(v_tl) + term_lo;
      ACC_LD_ANG: begin
        xa <= XW'(in_q.angle_location) - XW'(angle_origin) + XW'(angle_spacing)
              - prod_q[XW-1:0];
        ya <= prod_q[XW-1:0] + XW'(angle_origin) - XW'(in_q.angle_location);
      end
      ACC_LD_RAD: begin
        xr <= XW'(in_q.radius_location) - XW'(radius_origin) + XW'(radius_spacing)
              - prod_q[XW-1:0];
        yr <= prod_q[XW-1:0] + XW'(radius_origin) - XW'(in_q.radius_location);
      end
      default: begin
      end
    endcase

    unique case (cmd.st)
      ST_NONE: begin
      end
      ST_WTR:  wtr       <= acc_sat;
      ST_WTL:  wtl       <= acc_sat;
      ST_WRU:  wru       <= acc_sat;
      ST_WRL:  wrl       <= acc_sat;
      ST_TOP:  top       <= acc_sat;
      ST_BOT:  bot       <= acc_sat;
      ST_RES:  res_value <= acc_sat;
      ST_ZERO: res_value <= '0;
      default: begin
      end
    endcase

    case (cmd.cap)
      CAP_TR:  v_tr <= ram_rdata;
      CAP_TL:  v_tl <= ram_rdata;
      CAP_BR:  v_br <= ram_rdata;
      CAP_BL:  v_bl <= ram_rdata;
      default: begin
      end
    endcase

    if (cmd.out_load) begin
      out_data.interpolated_value <= res_value;
      out_data.status             <= ~ok;
    end
  end

endmodule

FILE: rtl/periodic_polar_grid_interpolator_top.sv
// Periodic polar grid interpolator: the value table is written one entry per input word and
// queried bilinearly over a radius/angle cell or linearly along angle within one radius row,
// all in signed Q16.16 with the angle index wrapping at both ends and results saturated to
// 32 bits. Words are handled one at a time, at a pace set by the single shared 34 by 34 bit
// multiplier, through which every weight and product passes in turn, and by the
// single-port table, read once per cycle. A finished result waits in the output register
// while the next word is taken in. The table is not cleared at reset; a query of an entry
// never written returns an undefined value. The user must write settings only while idle;
// the block itself does not enforce this. Depends on ppgi_pkg, ppgi_ctrl, ppgi_datapath
// and ppgi_ram.
module periodic_polar_grid_interpolator_top #(
  parameter int NUM_MODES  = ppgi_pkg::DEF_NUM_MODES,
  parameter int NUM_RADII  = ppgi_pkg::DEF_NUM_RADII,
  parameter int NUM_ANGLES = ppgi_pkg::DEF_NUM_ANGLES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ppgi_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ppgi_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [ppgi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppgi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppgi_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ppgi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ppgi_datapath #(
    .NUM_MODES  (NUM_MODES),
    .NUM_RADII  (NUM_RADII),
    .NUM_ANGLES (NUM_ANGLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
